### src/flvnal_pkg.sv
// ---------------------------------------------------------------------------
// flvnal_pkg: shared types and constants of the NAL unit splitter
// Word layouts passed into and out of the parser core.
// ---------------------------------------------------------------------------
package flvnal_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned TS_W   = 32;
    localparam int unsigned LSZ_W  = 3;
    localparam int unsigned HPOS_W = 3;
    localparam int unsigned PCNT_W = 3;

    localparam logic [HPOS_W-1:0] HDR_LEN      = 3'd5;
    localparam logic [BYTE_W-1:0] CODEC_MASK   = 8'h0F;
    localparam logic [BYTE_W-1:0] CODEC_AVC    = 8'd7;
    localparam logic [BYTE_W-1:0] PKT_NALU     = 8'd1;
    localparam logic [LSZ_W-1:0]  LSZ_RESET    = 3'd4;
    localparam logic [LSZ_W-1:0]  LSZ_MIN      = 3'd1;
    localparam logic [LSZ_W-1:0]  LSZ_MAX      = 3'd4;

    typedef struct packed {
        logic [TS_W-1:0]   timestamp;
        logic              message_last;
        logic [BYTE_W-1:0] body_byte;
    } in_word_t;

    typedef struct packed {
        logic [TS_W-1:0]   result_timestamp;
        logic              truncated;
        logic [LEN_W-1:0]  nal_length;
        logic              nal_end;
        logic              nal_start;
        logic              payload_valid;
        logic [BYTE_W-1:0] nal_byte;
    } res_word_t;

endpackage

### src/flvnal_in_stage.sv
// ---------------------------------------------------------------------------
// flvnal_in_stage: input word register
// Holds one accepted word until the parser core takes it.
// ---------------------------------------------------------------------------
module flvnal_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  flvnal_pkg::in_word_t in_word,
    output logic                hold_valid,
    input  logic                hold_take,
    output flvnal_pkg::in_word_t hold_word
);
    import flvnal_pkg::*;

    logic     valid_reg;
    in_word_t word_reg;

    assign in_ready   = !valid_reg || hold_take;
    assign hold_valid = valid_reg;
    assign hold_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            word_reg <= in_word;
        end
    end

endmodule

### src/flvnal_core.sv
// ---------------------------------------------------------------------------
// flvnal_core: tag header and length-prefix parser with result register
// Updates the parse state per word and registers a result word when one is produced.
// ---------------------------------------------------------------------------
module flvnal_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [2:0]            length_size,
    input  logic                  hold_valid,
    output logic                  hold_take,
    input  flvnal_pkg::in_word_t  hold_word,
    output logic                  res_valid,
    input  logic                  res_ready,
    output flvnal_pkg::res_word_t res_word
);
    import flvnal_pkg::*;

    logic [HPOS_W-1:0] hpos_reg, hpos_next;
    logic              split_reg, split_next;
    logic              inpay_reg, inpay_next;
    logic [PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic [LEN_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic              out_valid_reg;
    res_word_t         out_word_reg;

    logic              fire;
    logic              produce;
    res_word_t         res_calc;
    logic [LSZ_W-1:0]  lsz;
    logic [PCNT_W-1:0] pcnt_inc;
    logic [LEN_W-1:0]  acc_shift;
    logic              fin;

    assign hold_take = hold_valid && (!out_valid_reg || res_ready);
    assign fire      = hold_take;
    assign res_valid = out_valid_reg;
    assign res_word  = out_word_reg;

    // clamp out-of-range prefix sizes
    always_comb begin
        if (length_size < LSZ_MIN) begin
            lsz = LSZ_MIN;
        end else if (length_size > LSZ_MAX) begin
            lsz = LSZ_MAX;
        end else begin
            lsz = length_size;
        end
    end

    assign pcnt_inc  = pcnt_reg + 3'd1;
    assign acc_shift = {acc_reg[LEN_W-BYTE_W-1:0], hold_word.body_byte};
    assign fin       = (rem_reg <= 32'd1);

    always_comb begin
        hpos_next  = hpos_reg;
        split_next = split_reg;
        inpay_next = inpay_reg;
        pcnt_next  = pcnt_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        produce    = 1'b0;
        res_calc   = '0;
        res_calc.result_timestamp = hold_word.timestamp;
        if (fire) begin
            if (hpos_reg < HDR_LEN) begin
                if (hpos_reg == 3'd0) begin
                    split_next = (hold_word.body_byte & CODEC_MASK) == CODEC_AVC;
                end else if (hpos_reg == 3'd1) begin
                    split_next = split_reg && (hold_word.body_byte == PKT_NALU);
                end
                hpos_next = hpos_reg + 3'd1;
            end else if (split_reg) begin
                if (!inpay_reg) begin
                    acc_next  = acc_shift;
                    pcnt_next = pcnt_inc;
                    if (pcnt_inc >= lsz) begin
                        pcnt_next = '0;
                        if (acc_shift == '0) begin
                            produce            = 1'b1;
                            res_calc.nal_start = 1'b1;
                            res_calc.nal_end   = 1'b1;
                        end else if (hold_word.message_last) begin
                            produce             = 1'b1;
                            res_calc.nal_start  = 1'b1;
                            res_calc.nal_end    = 1'b1;
                            res_calc.nal_length = acc_shift;
                            res_calc.truncated  = 1'b1;
                        end else begin
                            inpay_next = 1'b1;
                            rem_next   = acc_shift;
                        end
                    end else if (hold_word.message_last) begin
                        produce            = 1'b1;
                        res_calc.nal_end   = 1'b1;
                        res_calc.truncated = 1'b1;
                    end
                end else begin
                    produce                = 1'b1;
                    res_calc.nal_byte      = hold_word.body_byte;
                    res_calc.payload_valid = 1'b1;
                    res_calc.nal_start     = (rem_reg == acc_reg);
                    res_calc.nal_end       = fin || hold_word.message_last;
                    res_calc.nal_length    = acc_reg;
                    res_calc.truncated     = hold_word.message_last && !fin;
                    rem_next               = rem_reg - 32'd1;
                    if (fin) begin
                        inpay_next = 1'b0;
                        rem_next   = '0;
                        acc_next   = '0;
                        pcnt_next  = '0;
                    end
                end
            end
            if (hold_word.message_last) begin
                hpos_next  = '0;
                split_next = 1'b0;
                inpay_next = 1'b0;
                pcnt_next  = '0;
                acc_next   = '0;
                rem_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hpos_reg      <= '0;
            split_reg     <= 1'b0;
            inpay_reg     <= 1'b0;
            pcnt_reg      <= '0;
            acc_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            hpos_reg  <= hpos_next;
            split_reg <= split_next;
            inpay_reg <= inpay_next;
            pcnt_reg  <= pcnt_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            if (fire) begin
                out_valid_reg <= produce;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && produce) begin
            out_word_reg <= res_calc;
        end
    end

endmodule

### src/flv_avc_nal_unit_splitter_top.sv
// ---------------------------------------------------------------------------
// flv_avc_nal_unit_splitter_top: AVC length-prefixed NAL unit splitter
// Path: an accepted word is held in the input register, then parsed and
// written to the result register, whose valid drives m_tvalid.
// Throughput: one body byte per cycle unless a result word waits on m_tready;
// input and result registers advance together, so words stream back to back.
// Reset: synchronous active-low aresetn clears parse state and valids;
// length_size returns to 4.
// ---------------------------------------------------------------------------
module flv_avc_nal_unit_splitter_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: length_size
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] body_byte, [39:8] timestamp
    input  logic        s_tlast,   // message_last
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [7:0] nal_byte, [39:8] nal_length,
                                   // [71:40] result_timestamp
    output logic [2:0]  m_tuser,   // [0] payload_valid, [1] nal_start,
                                   // [2] truncated
    output logic        m_tlast    // nal_end
);
    import flvnal_pkg::*;

    logic [LSZ_W-1:0] lsz_reg;
    in_word_t         s_word;
    in_word_t         hold_word;
    logic             hold_valid;
    logic             hold_take;
    res_word_t        res_word;

    // configuration is always taken; the user must apply it only while idle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lsz_reg <= LSZ_RESET;
        end else if (cfg_valid && cfg_ready) begin
            lsz_reg <= cfg_data;
        end
    end

    assign s_word.body_byte    = s_tdata[7:0];
    assign s_word.timestamp    = s_tdata[39:8];
    assign s_word.message_last = s_tlast;

    // hold the accepted word until the core can advance it
    flvnal_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_word    (s_word),
        .hold_valid (hold_valid),
        .hold_take  (hold_take),
        .hold_word  (hold_word)
    );

    // parse header and prefixes, register the result word
    flvnal_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .length_size (lsz_reg),
        .hold_valid  (hold_valid),
        .hold_take   (hold_take),
        .hold_word   (hold_word),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_word    (res_word)
    );

    assign m_tdata = {res_word.result_timestamp, res_word.nal_length, res_word.nal_byte};
    assign m_tuser = {res_word.truncated, res_word.nal_start, res_word.payload_valid};
    assign m_tlast = res_word.nal_end;

endmodule
